// ----- rtl/core/prrs_pkg.sv -----
// shared types, codes and default sizes of the priority round robin scheduler
package prrs_pkg;

	localparam int NUM_JOBS_DEF   = 64;
	localparam int NUM_LEVELS_DEF = 16;
	localparam int TIME_BITS_DEF  = 32;

	localparam int JOB_ID_W   = 6;
	localparam int PRIO_W     = 4;
	localparam int BURST_W    = 16;
	localparam int OUT_TIME_W = 32;

	localparam logic CMD_ARRIVAL = 1'b0;
	localparam logic CMD_TICK    = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ARR,
		ST_HEAD,
		ST_JOB,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic load;
		logic rd_slot;
		logic rd_job;
		logic commit_arr;
		logic commit_idle;
		logic commit_tick;
	} dp_cmd_t;

	typedef struct packed {
		logic new_tick;
		logic any_level;
		logic out_free;
	} dp_status_t;

endpackage

// ----- rtl/core/prrs_ctrl.sv -----
// sequencing state machine of the scheduler
module prrs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  prrs_pkg::dp_status_t status,
	output prrs_pkg::dp_cmd_t    ctl
);

	prrs_pkg::state_t state_q;
	prrs_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prrs_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			prrs_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_nxt = status.new_tick ? prrs_pkg::ST_HEAD : prrs_pkg::ST_ARR;
				end
			end
			prrs_pkg::ST_ARR: begin
				if (status.out_free) begin
					state_nxt = prrs_pkg::ST_IDLE;
				end
			end
			prrs_pkg::ST_HEAD: begin
				if (status.any_level) begin
					state_nxt = prrs_pkg::ST_JOB;
				end else if (status.out_free) begin
					state_nxt = prrs_pkg::ST_IDLE;
				end
			end
			prrs_pkg::ST_JOB: begin
				state_nxt = prrs_pkg::ST_UPD;
			end
			prrs_pkg::ST_UPD: begin
				if (status.out_free) begin
					state_nxt = prrs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = prrs_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl       = '0;
		req_ready = 1'b0;
		case (state_q)
			prrs_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				ctl.load  = req_valid;
			end
			prrs_pkg::ST_ARR: begin
				ctl.commit_arr = status.out_free;
			end
			prrs_pkg::ST_HEAD: begin
				ctl.rd_slot     = status.any_level;
				ctl.commit_idle = !status.any_level && status.out_free;
			end
			prrs_pkg::ST_JOB: begin
				ctl.rd_job = 1'b1;
			end
			prrs_pkg::ST_UPD: begin
				ctl.commit_tick = status.out_free;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

// ----- rtl/core/prrs_datapath.sv -----
// queue memories, job table, time counter and result register
module prrs_datapath #(
	parameter int NUM_JOBS   = prrs_pkg::NUM_JOBS_DEF,
	parameter int NUM_LEVELS = prrs_pkg::NUM_LEVELS_DEF,
	parameter int TIME_BITS  = prrs_pkg::TIME_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cmd,
	input  logic [prrs_pkg::JOB_ID_W-1:0]    job_id,
	input  logic [prrs_pkg::PRIO_W-1:0]      priority_req,
	input  logic [prrs_pkg::BURST_W-1:0]     burst,
	input  prrs_pkg::dp_cmd_t                ctl,
	output prrs_pkg::dp_status_t             status,
	output logic                             res_valid,
	input  logic                             res_ready,
	output logic                             idle,
	output logic [prrs_pkg::JOB_ID_W-1:0]    ran_job,
	output logic [prrs_pkg::OUT_TIME_W-1:0]  tick_start,
	output logic                             done_res,
	output logic [prrs_pkg::OUT_TIME_W-1:0]  start_time,
	output logic [prrs_pkg::OUT_TIME_W-1:0]  finish_time,
	output logic                             rejected
);

	localparam int JOB_W      = $clog2(NUM_JOBS);
	localparam int LVL_W      = $clog2(NUM_LEVELS);
	localparam int CNT_W      = $clog2(NUM_JOBS + 1);
	localparam int SLOT_DEPTH = NUM_LEVELS * NUM_JOBS;
	localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
	localparam int RED_W      = 17;
	localparam int SEL_W      = 9;

	typedef struct packed {
		logic [JOB_W-1:0] head;
		logic [JOB_W-1:0] tail;
		logic [CNT_W-1:0] count;
	} lvl_entry_t;

	typedef struct packed {
		logic                                started;
		logic [TIME_BITS-1:0]                first;
		logic [prrs_pkg::BURST_W-1:0]        rem;
	} job_entry_t;

	// id reduction by shifted compare and subtract, six steps for a six bit id
	function automatic logic [JOB_W-1:0] id_index(input logic [prrs_pkg::JOB_ID_W-1:0] id);
		logic [RED_W-1:0] r;
		logic [RED_W-1:0] m;
		r = RED_W'(id);
		for (int k = prrs_pkg::JOB_ID_W - 1; k >= 0; k--) begin
			m = RED_W'(NUM_JOBS) << k;
			if (r >= m) begin
				r = r - m;
			end
		end
		return JOB_W'(r);
	endfunction

	function automatic logic [JOB_W-1:0] ptr_inc(input logic [JOB_W-1:0] p);
		return (p == JOB_W'(NUM_JOBS - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [SLOT_AW-1:0] slot_addr(input logic [LVL_W-1:0] l,
		input logic [JOB_W-1:0] p);
		return SLOT_AW'(l) * SLOT_AW'(NUM_JOBS) + SLOT_AW'(p);
	endfunction

	function automatic logic [prrs_pkg::OUT_TIME_W-1:0] to_out(input logic [TIME_BITS-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[prrs_pkg::OUT_TIME_W-1:0];
	endfunction

	// item registers
	logic [JOB_W-1:0]              idx_q;
	logic [LVL_W-1:0]              lvl_q;
	logic [prrs_pkg::BURST_W-1:0]  burst_q;
	logic                          any_q;

	// control state
	logic [TIME_BITS-1:0]          time_q;
	logic [NUM_LEVELS-1:0]         nonempty_q;
	logic [NUM_LEVELS-1:0]         lvl_vld_q;
	logic                          res_valid_q;

	// memories and their registered read data
	lvl_entry_t                    lvl_mem [NUM_LEVELS];
	lvl_entry_t                    lvl_rd_q;
	logic                          lvl_hit_q;
	logic [JOB_W-1:0]              slot_mem [SLOT_DEPTH];
	logic [JOB_W-1:0]              slot_rd_q;
	job_entry_t                    job_mem [NUM_JOBS];
	job_entry_t                    job_rd_q;

	// result register
	logic                          idle_q;
	logic [prrs_pkg::JOB_ID_W-1:0] ran_job_q;
	logic [prrs_pkg::OUT_TIME_W-1:0] tick_start_q;
	logic                          done_q;
	logic [prrs_pkg::OUT_TIME_W-1:0] start_time_q;
	logic [prrs_pkg::OUT_TIME_W-1:0] finish_time_q;
	logic                          rejected_q;

	logic [JOB_W-1:0]              in_idx;
	logic [LVL_W-1:0]              in_lvl;
	logic [LVL_W-1:0]              sel_lvl;
	logic                          sel_any;
	lvl_entry_t                    lvl_cur;
	logic                          full;
	logic                          arr_ok;
	logic [prrs_pkg::BURST_W-1:0]  rem_nxt;
	logic                          done;
	logic [TIME_BITS-1:0]          first_nxt;
	logic [TIME_BITS-1:0]          time_nxt;
	logic                          slot_we;
	logic [SLOT_AW-1:0]            slot_wa;
	logic [JOB_W-1:0]              slot_wd;
	logic                          lvl_we;
	lvl_entry_t                    lvl_wd;
	logic                          job_we;
	logic [JOB_W-1:0]              job_wa;
	job_entry_t                    job_wd;
	logic                          res_load;

	assign in_idx = id_index(job_id);
	assign in_lvl = (SEL_W'(priority_req) > SEL_W'(NUM_LEVELS - 1)) ?
		LVL_W'(NUM_LEVELS - 1) : LVL_W'(priority_req);

	// lowest-numbered level holding work
	always_comb begin
		sel_lvl = '0;
		sel_any = 1'b0;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (nonempty_q[i]) begin
				sel_lvl = LVL_W'(i);
				sel_any = 1'b1;
			end
		end
	end

	assign lvl_cur   = lvl_hit_q ? lvl_rd_q : '0;
	assign full      = (lvl_cur.count == CNT_W'(NUM_JOBS));
	assign arr_ok    = ctl.commit_arr && !full;
	assign rem_nxt   = (job_rd_q.rem != '0) ? job_rd_q.rem - 1'b1 : '0;
	assign done      = (rem_nxt == '0);
	assign first_nxt = job_rd_q.started ? job_rd_q.first : time_q;
	assign time_nxt  = time_q + 1'b1;
	assign res_load  = ctl.commit_arr || ctl.commit_idle || ctl.commit_tick;

	always_comb begin
		slot_we = arr_ok || (ctl.commit_tick && !done);
		slot_wa = slot_addr(lvl_q, lvl_cur.tail);
		slot_wd = ctl.commit_tick ? slot_rd_q : idx_q;

		lvl_we = arr_ok || ctl.commit_tick;
		lvl_wd = lvl_cur;
		if (ctl.commit_tick) begin
			lvl_wd.head = ptr_inc(lvl_cur.head);
			if (done) begin
				lvl_wd.count = lvl_cur.count - 1'b1;
			end else begin
				lvl_wd.tail = ptr_inc(lvl_cur.tail);
			end
		end else begin
			lvl_wd.tail  = ptr_inc(lvl_cur.tail);
			lvl_wd.count = lvl_cur.count + 1'b1;
		end

		job_we = arr_ok || ctl.commit_tick;
		job_wa = ctl.commit_tick ? slot_rd_q : idx_q;
		if (ctl.commit_tick) begin
			job_wd = '{started: 1'b1, first: first_nxt, rem: rem_nxt};
		end else begin
			job_wd = '{started: 1'b0, first: '0, rem: burst_q};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			idx_q   <= in_idx;
			burst_q <= burst;
			any_q   <= sel_any;
			lvl_q   <= (cmd == prrs_pkg::CMD_TICK) ? sel_lvl : in_lvl;
		end
	end

	// per-level pointer memory, read on accept
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			lvl_rd_q  <= lvl_mem[(cmd == prrs_pkg::CMD_TICK) ? sel_lvl : in_lvl];
			lvl_hit_q <= lvl_vld_q[(cmd == prrs_pkg::CMD_TICK) ? sel_lvl : in_lvl];
		end
		if (lvl_we) begin
			lvl_mem[lvl_q] <= lvl_wd;
		end
	end

	// ready queue slots of all levels
	always_ff @(posedge clk) begin
		if (ctl.rd_slot) begin
			slot_rd_q <= slot_mem[slot_addr(lvl_q, lvl_cur.head)];
		end
		if (slot_we) begin
			slot_mem[slot_wa] <= slot_wd;
		end
	end

	// job table
	always_ff @(posedge clk) begin
		if (ctl.rd_job) begin
			job_rd_q <= job_mem[slot_rd_q];
		end
		if (job_we) begin
			job_mem[job_wa] <= job_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q      <= '0;
			nonempty_q  <= '0;
			lvl_vld_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (ctl.commit_idle || ctl.commit_tick) begin
				time_q <= time_nxt;
			end
			if (lvl_we) begin
				lvl_vld_q[lvl_q] <= 1'b1;
			end
			if (arr_ok) begin
				nonempty_q[lvl_q] <= 1'b1;
			end else if (ctl.commit_tick && done) begin
				nonempty_q[lvl_q] <= (lvl_cur.count != CNT_W'(1));
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			idle_q        <= ctl.commit_idle;
			ran_job_q     <= ctl.commit_tick ? prrs_pkg::JOB_ID_W'(slot_rd_q) : '0;
			tick_start_q  <= (ctl.commit_idle || ctl.commit_tick) ? to_out(time_q) : '0;
			done_q        <= ctl.commit_tick && done;
			start_time_q  <= (ctl.commit_tick && done) ? to_out(first_nxt) : '0;
			finish_time_q <= (ctl.commit_tick && done) ? to_out(time_nxt) : '0;
			rejected_q    <= ctl.commit_arr && full;
		end
	end

	assign status.new_tick  = (cmd == prrs_pkg::CMD_TICK);
	assign status.any_level = any_q;
	assign status.out_free  = !res_valid_q || res_ready;

	assign res_valid   = res_valid_q;
	assign idle        = idle_q;
	assign ran_job     = ran_job_q;
	assign tick_start  = tick_start_q;
	assign done_res    = done_q;
	assign start_time  = start_time_q;
	assign finish_time = finish_time_q;
	assign rejected    = rejected_q;

endmodule

// ----- rtl/core/priority_round_robin_scheduler_core.sv -----
// top level of the multilevel priority round robin scheduler
//
//  channel | beat                                          | handshake
//  --------+-----------------------------------------------+----------------------
//  req     | cmd, job_id, priority_req, burst              | req_valid / req_ready
//  res     | idle, ran_job, tick_start, done_res,          | res_valid / res_ready
//          | start_time, finish_time, rejected             |
//
//  one beat at a time is in work; one result beat for every request beat
//  arrival: pointer memory read, then queue, pointer and job table write
//  idle tick: pointer memory read, then the result write; running tick: the chain of three
//  synchronous memory reads (level pointers, queue slot, job table) and the write back
//  a result waiting in the output register holds the block only at its final step
//  reset clears time, level flags and pointer valid bits; no clearing pass runs
module priority_round_robin_scheduler_core #(
	parameter int NUM_JOBS   = prrs_pkg::NUM_JOBS_DEF,
	parameter int NUM_LEVELS = prrs_pkg::NUM_LEVELS_DEF,
	parameter int TIME_BITS  = prrs_pkg::TIME_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic                             cmd,
	input  logic [prrs_pkg::JOB_ID_W-1:0]    job_id,
	input  logic [prrs_pkg::PRIO_W-1:0]      priority_req,
	input  logic [prrs_pkg::BURST_W-1:0]     burst,
	output logic                             res_valid,
	input  logic                             res_ready,
	output logic                             idle,
	output logic [prrs_pkg::JOB_ID_W-1:0]    ran_job,
	output logic [prrs_pkg::OUT_TIME_W-1:0]  tick_start,
	output logic                             done_res,
	output logic [prrs_pkg::OUT_TIME_W-1:0]  start_time,
	output logic [prrs_pkg::OUT_TIME_W-1:0]  finish_time,
	output logic                             rejected
);

	// commands from the sequencer, status back from the datapath
	prrs_pkg::dp_cmd_t    ctl;
	prrs_pkg::dp_status_t status;

	prrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.status    (status),
		.ctl       (ctl)
	);

	// memories, time base and the result register live here
	prrs_datapath #(
		.NUM_JOBS   (NUM_JOBS),
		.NUM_LEVELS (NUM_LEVELS),
		.TIME_BITS  (TIME_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.job_id       (job_id),
		.priority_req (priority_req),
		.burst        (burst),
		.ctl          (ctl),
		.status       (status),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.idle         (idle),
		.ran_job      (ran_job),
		.tick_start   (tick_start),
		.done_res     (done_res),
		.start_time   (start_time),
		.finish_time  (finish_time),
		.rejected     (rejected)
	);

`ifndef SYNTH
	// a new beat is taken only once the previous one is finished
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while a beat was in work");

	// at most one kind of result written per cycle
	a_one_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.commit_arr, ctl.commit_idle, ctl.commit_tick}))
		else $error("more than one result written in a cycle");

	// a running tick needs a level that held work when it was taken
	a_tick_has_level: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit_tick |-> status.any_level)
		else $error("job run on a tick with no ready level");

	// a finished job is never reported as idle or refused
	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> !idle && !rejected)
		else $error("finished result carries idle or reject flag");
`endif

endmodule

// ----- dv/tb.sv -----
// self-checking testbench of the priority round robin scheduler core
`timescale 1ns / 100ps

module tb;

	// block sizes as built with the package defaults
	localparam int NJOBS   = prrs_pkg::NUM_JOBS_DEF;
	localparam int NLEVELS = prrs_pkg::NUM_LEVELS_DEF;

	// receiver hold-off, no-progress limit and tail after the last result, in cycles
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 4000;
	localparam int TAIL_CYCLES  = 16;

	// idling phases of the run
	typedef enum int {
		PH_NO_IDLE,
		PH_SEND_GAPS,
		PH_RECV_STALLS,
		PH_BOTH_GAPS
	} idle_mode_t;

	// one request beat as offered on the req channel
	typedef struct {
		logic                            cmd;
		logic [prrs_pkg::JOB_ID_W-1:0]   job_id;
		logic [prrs_pkg::PRIO_W-1:0]     prio;
		logic [prrs_pkg::BURST_W-1:0]    burst;
	} req_beat_t;

	// one result beat as expected on the res channel
	typedef struct {
		logic                             idle;
		logic [prrs_pkg::JOB_ID_W-1:0]    ran_job;
		logic [prrs_pkg::OUT_TIME_W-1:0]  tick_start;
		logic                             done_res;
		logic [prrs_pkg::OUT_TIME_W-1:0]  start_time;
		logic [prrs_pkg::OUT_TIME_W-1:0]  finish_time;
		logic                             rejected;
	} sched_res_t;

	// clock, reset and the inputs driven here, all known from time zero
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                             req_valid    = 1'b0;
	logic                             req_ready;
	logic                             cmd          = prrs_pkg::CMD_ARRIVAL;
	logic [prrs_pkg::JOB_ID_W-1:0]    job_id       = '0;
	logic [prrs_pkg::PRIO_W-1:0]      priority_req = '0;
	logic [prrs_pkg::BURST_W-1:0]     burst        = '0;
	logic                             res_valid;
	logic                             res_ready    = 1'b0;
	logic                             idle;
	logic [prrs_pkg::JOB_ID_W-1:0]    ran_job;
	logic [prrs_pkg::OUT_TIME_W-1:0]  tick_start;
	logic                             done_res;
	logic [prrs_pkg::OUT_TIME_W-1:0]  start_time;
	logic [prrs_pkg::OUT_TIME_W-1:0]  finish_time;
	logic                             rejected;

	// beats waiting to be offered and results waiting to come back
	req_beat_t  pending_beats [$];
	sched_res_t due_results [$];

	// shadow of the scheduler state
	logic [prrs_pkg::OUT_TIME_W-1:0]  now_time;
	logic [prrs_pkg::BURST_W-1:0]     work_left [NJOBS];
	logic [prrs_pkg::OUT_TIME_W-1:0]  first_tick [NJOBS];
	logic                             started [NJOBS];
	logic [prrs_pkg::JOB_ID_W-1:0]    lvl_slot [NLEVELS][NJOBS];
	logic [prrs_pkg::JOB_ID_W-1:0]    lvl_head [NLEVELS];
	logic [prrs_pkg::JOB_ID_W-1:0]    lvl_tail [NLEVELS];
	logic [prrs_pkg::JOB_ID_W:0]      lvl_count [NLEVELS];

	// run control shared between the stimulus and the clocked processes
	idle_mode_t idle_mode = PH_NO_IDLE;
	int hold_asks = 0;
	int hold_seen;
	int hold_left;
	int quiet_cycles;
	int items_queued = 0;
	int mismatches = 0;

	// coverage tallies taken from the accepted beats
	int n_arrivals = 0;
	int n_ticks = 0;
	int n_idle = 0;
	int n_done = 0;
	int n_rejected = 0;

	priority_round_robin_scheduler_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.cmd          (cmd),
		.job_id       (job_id),
		.priority_req (priority_req),
		.burst        (burst),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.idle         (idle),
		.ran_job      (ran_job),
		.tick_start   (tick_start),
		.done_res     (done_res),
		.start_time   (start_time),
		.finish_time  (finish_time),
		.rejected     (rejected)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// appends a beat to the offer queue
	function automatic void add_pending(req_beat_t b);
		pending_beats.insert(pending_beats.size(), b);
	endfunction

	// appends an expected result
	function automatic void add_due(sched_res_t r);
		due_results.insert(due_results.size(), r);
	endfunction

	// advances the shadow scheduler by one accepted beat and returns its result
	function automatic sched_res_t schedule_beat(req_beat_t b);
		sched_res_t r;
		int lvl;
		logic [prrs_pkg::JOB_ID_W-1:0] j;
		logic [prrs_pkg::OUT_TIME_W-1:0] t;
		r = '{default: '0};
		j = b.job_id;
		if (b.cmd == prrs_pkg::CMD_ARRIVAL) begin
			// full level refuses and leaves everything as it was
			lvl = int'(b.prio);
			if (lvl_count[lvl] >= NJOBS) begin
				r.rejected = 1'b1;
				return r;
			end
			// a repeated id reloads the shared job entry
			work_left[j] = b.burst;
			started[j] = 1'b0;
			lvl_slot[lvl][lvl_tail[lvl]] = j;
			lvl_tail[lvl] = lvl_tail[lvl] + 1'b1;
			lvl_count[lvl] = lvl_count[lvl] + 1'b1;
			return r;
		end
		t = now_time;
		r.tick_start = t;
		now_time = t + 1'b1;
		// lowest-numbered level holding a job wins
		lvl = -1;
		for (int l = NLEVELS - 1; l >= 0; l--)
			if (lvl_count[l] != 0)
				lvl = l;
		if (lvl < 0) begin
			r.idle = 1'b1;
			return r;
		end
		j = lvl_slot[lvl][lvl_head[lvl]];
		lvl_head[lvl] = lvl_head[lvl] + 1'b1;
		lvl_count[lvl] = lvl_count[lvl] - 1'b1;
		r.ran_job = j;
		if (!started[j]) begin
			started[j] = 1'b1;
			first_tick[j] = t;
		end
		// zero work saturates, so such a job finishes after its one tick
		if (work_left[j] != 0)
			work_left[j] = work_left[j] - 1'b1;
		if (work_left[j] == 0) begin
			r.done_res = 1'b1;
			r.start_time = first_tick[j];
			r.finish_time = now_time;
		end else begin
			lvl_slot[lvl][lvl_tail[lvl]] = j;
			lvl_tail[lvl] = lvl_tail[lvl] + 1'b1;
			lvl_count[lvl] = lvl_count[lvl] + 1'b1;
		end
		return r;
	endfunction

	// percentage of cycles one side spends idle in the current phase
	function automatic int gap_pct(bit sender);
		case (idle_mode)
			PH_SEND_GAPS:   return sender ? 77 : 0;
			PH_RECV_STALLS: return sender ? 0 : 77;
			PH_BOTH_GAPS:   return 9;
			default:        return 0;
		endcase
	endfunction

	task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
			mismatches++;
		end
	endtask

	// req side: offers the next pending beat unless a gap is rolled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			cmd <= prrs_pkg::CMD_ARRIVAL;
			job_id <= '0;
			priority_req <= '0;
			burst <= '0;
		end else if (!req_valid || req_ready) begin
			if (pending_beats.size() != 0 && $urandom_range(99) >= gap_pct(1'b1)) begin
				req_valid <= 1'b1;
				cmd <= pending_beats[0].cmd;
				job_id <= pending_beats[0].job_id;
				priority_req <= pending_beats[0].prio;
				burst <= pending_beats[0].burst;
				void'(pending_beats.pop_front());
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// res side: random stalls, plus a long hold-off whenever one is asked for
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			hold_seen <= 0;
			hold_left <= 0;
		end else if (hold_seen != hold_asks) begin
			hold_seen <= hold_asks;
			hold_left <= HOLD_CYCLES;
			res_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_ready <= 1'b0;
		end else begin
			res_ready <= $urandom_range(99) >= gap_pct(1'b0);
		end
	end

	// predicts on every accepted req beat, checks every accepted res beat
	always @(posedge clk or negedge arst_n) begin
		sched_res_t want;
		req_beat_t got;
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if (req_valid && req_ready) begin
				got.cmd = cmd;
				got.job_id = job_id;
				got.prio = priority_req;
				got.burst = burst;
				want = schedule_beat(got);
				add_due(want);
				if (cmd == prrs_pkg::CMD_ARRIVAL) begin
					n_arrivals++;
					n_rejected += want.rejected;
				end else begin
					n_ticks++;
					n_idle += want.idle;
					n_done += want.done_res;
				end
			end
			if (res_valid && res_ready) begin
				if (due_results.size() == 0) begin
					$error("result beat with no expectation waiting");
					mismatches++;
				end else begin
					want = due_results.pop_front();
					check_field("idle", 32'(want.idle), 32'(idle));
					check_field("ran_job", 32'(want.ran_job), 32'(ran_job));
					check_field("tick_start", want.tick_start, tick_start);
					check_field("done_res", 32'(want.done_res), 32'(done_res));
					check_field("start_time", want.start_time, start_time);
					check_field("finish_time", want.finish_time, finish_time);
					check_field("rejected", 32'(want.rejected), 32'(rejected));
				end
			end
			// watchdog on cycles where neither channel moves a beat
			if ((req_valid && req_ready) || (res_valid && res_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
				$display("** priority_round_robin_scheduler_core: FAILED **");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic queue_arrival(int id, int prio, int work);
		req_beat_t b;
		b.cmd = prrs_pkg::CMD_ARRIVAL;
		b.job_id = prrs_pkg::JOB_ID_W'(id);
		b.prio = prrs_pkg::PRIO_W'(prio);
		b.burst = prrs_pkg::BURST_W'(work);
		add_pending(b);
		items_queued++;
	endtask

	task automatic queue_tick();
		req_beat_t b;
		b.cmd = prrs_pkg::CMD_TICK;
		b.job_id = prrs_pkg::JOB_ID_W'($urandom_range(63));
		b.prio = prrs_pkg::PRIO_W'($urandom_range(15));
		b.burst = prrs_pkg::BURST_W'($urandom_range(16'hFFFF));
		add_pending(b);
		items_queued++;
	endtask

	// mostly short scheduling rounds: a few arrivals, then one to six ticks
	task automatic queue_traffic(int n);
		int target;
		int k;
		target = items_queued + n;
		while (items_queued < target) begin
			if ($urandom_range(99) < 85) begin
				k = $urandom_range(3);
				repeat (k)
					queue_arrival($urandom_range(63), $urandom_range(15), $urandom_range(1, 6));
				// a rare very long job, kept on the last level so it cannot starve the rest
				if ($urandom_range(49) == 0)
					queue_arrival($urandom_range(63), NLEVELS - 1, $urandom_range(16'hFFFF));
				repeat ($urandom_range(1, 6))
					queue_tick();
			end else if ($urandom_range(1) == 0) begin
				// stray arrival, zero work allowed
				queue_arrival($urandom_range(63), $urandom_range(15), $urandom_range(15));
			end else begin
				queue_tick();
			end
		end
	endtask

	// waits until every offered beat has come back as a result
	task automatic drain();
		while (pending_beats.size() != 0 || req_valid || due_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int lvl;
		now_time = '0;
		for (int i = 0; i < NLEVELS; i++) begin
			lvl_head[i] = '0;
			lvl_tail[i] = '0;
			lvl_count[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// empty system gives an idle tick at time zero
		queue_tick();
		// single job of one tick
		queue_arrival(0, 0, 1);
		queue_tick();
		// longest job beside a zero-work job on the last level
		queue_arrival(63, 15, 16'hFFFF);
		queue_arrival(5, 15, 0);
		queue_tick();
		queue_tick();
		queue_tick();
		// re-arrival of a queued id reloads it; both queue entries then finish it
		queue_arrival(63, 15, 1);
		queue_tick();
		queue_tick();
		queue_tick();
		// priority order and round robin inside a level
		queue_arrival(42, 10, 2);
		queue_arrival(21, 5, 2);
		queue_arrival(7, 5, 1);
		repeat (6) queue_tick();
		queue_arrival(16'h2A, 16'hA, 16'hAAAA & 16'h0003);
		queue_arrival(16'h15, 16'h5, 16'h5555 & 16'h0003);
		repeat (6) queue_tick();
		drain();

		// no idling, with a long receiver hold-off that backs up the input
		idle_mode = PH_NO_IDLE;
		queue_traffic(190);
		hold_asks++;
		drain();

		idle_mode = PH_SEND_GAPS;
		queue_traffic(190);
		drain();

		// receiver stalls, led by filling one level past its depth
		idle_mode = PH_RECV_STALLS;
		lvl = $urandom_range(NLEVELS - 2);
		repeat (NJOBS + 2)
			queue_arrival($urandom_range(63), lvl, 1);
		repeat (NJOBS + 4)
			queue_tick();
		queue_traffic(120);
		drain();

		idle_mode = PH_BOTH_GAPS;
		queue_traffic(190);
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d arrivals (%0d refused by a full level) and %0d ticks",
			n_arrivals, n_rejected, n_ticks);
		$display("of which %0d idle and %0d finished a job, %0d mismatches",
			n_idle, n_done, mismatches);
		if (mismatches == 0) begin
			$display("** priority_round_robin_scheduler_core: PASSED **");
		end else begin
			$display("** priority_round_robin_scheduler_core: FAILED **");
		end
		$finish;
	end

endmodule
